FILE: rtl/sls_pkg.sv
// Shared types and constants for the size-limited range segmenter.
// No dependencies; used by every module in rtl/.
package sls_pkg;

    localparam int BYTES_W       = 64;
    localparam int LVL_W         = 8;
    localparam int IDX_W         = 5;
    localparam int PE_W          = 6;
    localparam int DEF_NUM_COSTS = 64;
    localparam int DEF_MAX_PARTS = 32;
    localparam int DEF_Q_DEPTH   = 4;

    // One emitted part.
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [LVL_W-1:0]   first;
        logic [LVL_W-1:0]   final_lvl;
        logic [BYTES_W-1:0] bytes;
        logic               over;
    } part_rec_t;

    // Queue entry: the parts caused by one level (one or two).
    typedef struct packed {
        part_rec_t rec0;
        part_rec_t rec1;
        logic      two;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

endpackage

FILE: rtl/sls_front.sv
// Front end: level size subtraction, then next-fit packing decision.
// Depends on sls_pkg; pushes finished parts into sls_queue.
module sls_front
    import sls_pkg::*;
#(
    parameter int NUM_COSTS = DEF_NUM_COSTS,
    parameter int MAX_PARTS = DEF_MAX_PARTS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  logic [BYTES_W-1:0] cumulative_bytes,
    input  logic [BYTES_W-1:0] part_limit,
    output q_push_t            push
);

    localparam logic [LVL_W-1:0] LastLvl = LVL_W'(NUM_COSTS - 1);
    localparam logic [PE_W-1:0]  CapVal  = PE_W'(MAX_PARTS);

    // stage 1: difference against previous total
    logic               s1_valid_reg;
    logic [BYTES_W-1:0] s1_size_reg;
    logic [LVL_W-1:0]   s1_level_reg;
    logic               s1_last_reg;
    logic [BYTES_W-1:0] prev_total_reg;
    logic [LVL_W-1:0]   level_reg;
    logic               in_last;

    assign in_last = (level_reg == LastLvl);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            prev_total_reg <= '0;
            level_reg      <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            if (in_valid)
            begin
                prev_total_reg <= in_last ? '0 : cumulative_bytes;
                level_reg      <= in_last ? '0 : level_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            s1_size_reg  <= cumulative_bytes - prev_total_reg;
            s1_level_reg <= level_reg;
            s1_last_reg  <= in_last;
        end
    end

    // stage 2: packing state
    logic [LVL_W-1:0]   open_start_reg, open_start_next;
    logic [BYTES_W-1:0] open_bytes_reg, open_bytes_next;
    logic [PE_W-1:0]    parts_reg, parts_next;

    logic [BYTES_W:0]   sum;
    logic               big, over_sum, open_nz, open_over;
    part_rec_t          c0, c1;
    logic [1:0]         ncand, nacc;
    logic [PE_W-1:0]    pe_plus1;

    always_comb
    begin
        sum       = {1'b0, open_bytes_reg} + {1'b0, s1_size_reg};
        big       = s1_size_reg > part_limit;
        over_sum  = sum > {1'b0, part_limit};
        open_nz   = (open_bytes_reg != '0);
        open_over = open_bytes_reg > part_limit;
        pe_plus1  = parts_reg + 1'b1;

        c0 = '0;
        c1 = '0;
        c0.idx = parts_reg[IDX_W-1:0];
        c1.idx = pe_plus1[IDX_W-1:0];
        ncand  = 2'd0;
        open_start_next = open_start_reg;
        open_bytes_next = open_bytes_reg;

        // record of the currently open part, closed before this level
        if (big)
        begin
            if (open_nz)
            begin
                c0.first     = open_start_reg;
                c0.final_lvl = s1_level_reg - 1'b1;
                c0.bytes     = open_bytes_reg;
                c0.over      = open_over;
                c1.first     = s1_level_reg;
                c1.final_lvl = s1_level_reg;
                c1.bytes     = s1_size_reg;
                c1.over      = 1'b1;
                ncand        = 2'd2;
            end
            else
            begin
                c0.first     = s1_level_reg;
                c0.final_lvl = s1_level_reg;
                c0.bytes     = s1_size_reg;
                c0.over      = 1'b1;
                ncand        = 2'd1;
            end
            open_start_next = s1_level_reg + 1'b1;
            open_bytes_next = '0;
        end
        else if (over_sum && open_nz)
        begin
            c0.first        = open_start_reg;
            c0.final_lvl    = s1_level_reg - 1'b1;
            c0.bytes        = open_bytes_reg;
            c0.over         = open_over;
            ncand           = 2'd1;
            open_start_next = s1_level_reg;
            open_bytes_next = s1_size_reg;
        end
        else
        begin
            open_bytes_next = sum[BYTES_W-1:0];
        end

        // flush at the end of the run; the open part never exceeds the limit here
        if (s1_last_reg && (open_bytes_next != '0))
        begin
            if (ncand == 2'd0)
            begin
                c0.first     = open_start_next;
                c0.final_lvl = s1_level_reg;
                c0.bytes     = open_bytes_next;
                c0.over      = 1'b0;
                ncand        = 2'd1;
            end
            else
            begin
                c1.first     = open_start_next;
                c1.final_lvl = s1_level_reg;
                c1.bytes     = open_bytes_next;
                c1.over      = 1'b0;
                ncand        = 2'd2;
            end
        end

        // part cap
        if (ncand == 2'd0 || parts_reg >= CapVal)
            nacc = 2'd0;
        else if (ncand == 2'd2 && pe_plus1 >= CapVal)
            nacc = 2'd1;
        else
            nacc = ncand;

        parts_next = parts_reg + PE_W'(nacc);

        if (s1_last_reg)
        begin
            open_start_next = '0;
            open_bytes_next = '0;
            parts_next      = '0;
        end

        push.valid     = advance && s1_valid_reg && (nacc != 2'd0);
        push.entry.rec0 = c0;
        push.entry.rec1 = c1;
        push.entry.two  = (nacc == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_start_reg <= '0;
            open_bytes_reg <= '0;
            parts_reg      <= '0;
        end
        else if (advance && s1_valid_reg)
        begin
            open_start_reg <= open_start_next;
            open_bytes_reg <= open_bytes_next;
            parts_reg      <= parts_next;
        end
    end

endmodule

FILE: rtl/sls_queue.sv
// Small register FIFO of part entries between front and back end.
// Depends on sls_pkg.
module sls_queue
    import sls_pkg::*;
#(
    parameter int DEPTH = DEF_Q_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  q_push_t  push,
    input  logic     pop,
    output q_entry_t head,
    output logic     empty,
    output logic     full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

    q_entry_t        slots [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/sls_back.sv
// Back end: walks the one or two parts of the head entry onto the output.
// Depends on sls_pkg; reads sls_queue head.
module sls_back
    import sls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  q_entry_t           head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [IDX_W-1:0]   part_index,
    output logic [LVL_W-1:0]   first_cost,
    output logic [LVL_W-1:0]   final_cost,
    output logic [BYTES_W-1:0] part_bytes,
    output logic               oversized,
    output logic               last_of_run
);

    logic      sel_reg;
    part_rec_t cur;
    logic      beat;

    assign cur         = sel_reg ? head.rec1 : head.rec0;
    assign out_valid   = !empty;
    assign beat        = out_valid && !out_stall;
    assign last_of_run = sel_reg || !head.two;
    assign pop         = beat && last_of_run;

    assign part_index = cur.idx;
    assign first_cost = cur.first;
    assign final_cost = cur.final_lvl;
    assign part_bytes = cur.bytes;
    assign oversized  = cur.over;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else if (beat)
            sel_reg <= !last_of_run;
    end

endmodule

FILE: rtl/size_limited_range_segmenter_core.sv
// Size-limited range segmenter, top level: part limit register, front, queue, back.
// A level's first part passes the stage-1 registers and a queue slot before out_valid
// rises for it. Throughput: one level per cycle while in_stall is low; the output
// moves one part per cycle while out_stall is low, a two-part level takes two output
// beats, and in_stall rises only while the queue is full.
// Reset (rst_n, async low): run state and queue cleared, part limit all ones.
module size_limited_range_segmenter_core
    import sls_pkg::*;
#(
    parameter int NUM_COSTS   = DEF_NUM_COSTS,
    parameter int MAX_PARTS   = DEF_MAX_PARTS,
    parameter int QUEUE_DEPTH = DEF_Q_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    // config write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BYTES_W-1:0] part_limit,
    // level totals in
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTES_W-1:0] cumulative_bytes,
    // parts out
    output logic               out_valid,
    input  logic               out_stall,
    output logic [IDX_W-1:0]   part_index,
    output logic [LVL_W-1:0]   first_cost,
    output logic [LVL_W-1:0]   final_cost,
    output logic [BYTES_W-1:0] part_bytes,
    output logic               oversized,
    output logic               last_of_run
);

    logic [BYTES_W-1:0] part_limit_reg;
    q_push_t            q_push;
    q_entry_t           q_head;
    logic               q_empty, q_full, q_pop;
    logic               advance;

    // Config beats are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            part_limit_reg <= '1;
        else if (cfg_valid && cfg_ready)
            part_limit_reg <= part_limit;
    end

    // The whole front moves together; it halts only when the queue is full,
    // so a decision is never made without room to store its parts.
    assign advance  = !q_full;
    assign in_stall = q_full;

    sls_front #(
        .NUM_COSTS (NUM_COSTS),
        .MAX_PARTS (MAX_PARTS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .in_valid         (in_valid),
        .cumulative_bytes (cumulative_bytes),
        .part_limit       (part_limit_reg),
        .push             (q_push)
    );

    sls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty),
        .full  (q_full)
    );

    sls_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .empty       (q_empty),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .part_index  (part_index),
        .first_cost  (first_cost),
        .final_cost  (final_cost),
        .part_bytes  (part_bytes),
        .oversized   (oversized),
        .last_of_run (last_of_run)
    );

    // No push may be lost to a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push.valid && q_full))
        else $error("part entry pushed into full queue");

    // The first part of a pair is always followed by its partner.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |=> out_valid)
        else $error("second part of a level went missing");

    // Part numbers stay under the cap.
    a_index_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, part_index} < PE_W'(MAX_PARTS)))
        else $error("part index beyond part cap");

endmodule

FILE: test/size_limited_range_segmenter_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for size_limited_range_segmenter_core (default parameters).
// Depends on rtl/sls_pkg.sv and the core; carries its own next-fit segmentation model.
module size_limited_range_segmenter_core_test
    import sls_pkg::*;
();

    localparam int NUM_LEVELS   = DEF_NUM_COSTS;
    localparam int PART_CAP     = DEF_MAX_PARTS;
    localparam int DRAIN_CYCLES = 8;       // margin for levels with no part
    localparam int LIMIT_CYCLES = 2000000;
    localparam int RANDOM_BEATS = 1600;
    localparam int MAX_REPORTS  = 10;

    // One expected output beat, laid out field by field.
    typedef struct packed {
        logic [IDX_W-1:0]   part_index;
        logic [LVL_W-1:0]   first_cost;
        logic [LVL_W-1:0]   final_cost;
        logic [BYTES_W-1:0] part_bytes;
        logic               oversized;
        logic               last_of_run;
    } part_beat_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [BYTES_W-1:0] part_limit;
    logic               in_valid;
    logic               in_stall;
    logic [BYTES_W-1:0] cumulative_bytes;
    logic               out_valid;
    logic               out_stall;
    logic [IDX_W-1:0]   part_index;
    logic [LVL_W-1:0]   first_cost;
    logic [LVL_W-1:0]   final_cost;
    logic [BYTES_W-1:0] part_bytes;
    logic               oversized;
    logic               last_of_run;

    size_limited_range_segmenter_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .part_limit       (part_limit),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cumulative_bytes (cumulative_bytes),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .part_index       (part_index),
        .first_cost       (first_cost),
        .final_cost       (final_cost),
        .part_bytes       (part_bytes),
        .oversized        (oversized),
        .last_of_run      (last_of_run)
    );

    // Segmenter model state: limit register plus the run state of the block.
    logic [BYTES_W-1:0] seg_limit;
    logic [BYTES_W-1:0] seg_prev_total;
    logic [LVL_W-1:0]   seg_open_start;
    logic [BYTES_W-1:0] seg_open_bytes;
    logic [LVL_W-1:0]   seg_level;
    int                 seg_parts;

    // Parts produced by the level being modeled (never more than two).
    part_beat_t         step_parts [2];
    int                 step_count;

    // Parts still owed by the block, oldest first.
    part_beat_t         pending_parts [$];

    logic [BYTES_W-1:0] last_total;    // last total offered, for building the next one
    bit                 gaps_on;
    int                 hold_request;  // receiver picks this up and stalls that long
    int                 stall_left;
    bit                 stall_now;

    int                 errors;
    int                 beats_sent;
    int                 parts_checked;
    int                 limit_writes;
    int                 cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a run that hangs ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d parts still owed", cycle_count,
                 pending_parts.size());
        $display("tb: failure");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch %0d: %s", errors, msg);
    endtask

    // Queue one part of the current level, honoring the per-run cap.
    function automatic void add_part(input logic [LVL_W-1:0] first, input logic [LVL_W-1:0] fin,
                                     input logic [BYTES_W-1:0] bytes);
        part_beat_t p;
        if (seg_parts >= PART_CAP || step_count >= 2)
            return;
        p.part_index  = seg_parts[IDX_W-1:0];
        p.first_cost  = first;
        p.final_cost  = fin;
        p.part_bytes  = bytes;
        p.oversized   = (bytes > seg_limit);
        p.last_of_run = 1'b0;
        step_parts[step_count] = p;
        step_count++;
        seg_parts++;
    endfunction

    // Next-fit packing of one level; expected parts go to pending_parts.
    task automatic segment_level(input logic [BYTES_W-1:0] total);
        logic [BYTES_W-1:0] size;
        logic [BYTES_W:0]   sum;
        logic               over_limit;
        logic [LVL_W-1:0]   lvl;
        size = total - seg_prev_total;               // wraps on a decreasing total
        sum = {1'b0, seg_open_bytes} + {1'b0, size};  // carry counts as over the limit
        over_limit = sum[BYTES_W] || (sum[BYTES_W-1:0] > seg_limit);
        lvl = seg_level;
        step_count = 0;
        if (size > seg_limit)
        begin
            // oversized level: close the open part, then stand alone
            if (seg_open_bytes != '0)
                add_part(seg_open_start, lvl - 1'b1, seg_open_bytes);
            add_part(lvl, lvl, size);
            seg_open_start = lvl + 1'b1;
            seg_open_bytes = '0;
        end
        else if (over_limit && seg_open_bytes != '0)
        begin
            add_part(seg_open_start, lvl - 1'b1, seg_open_bytes);
            seg_open_start = lvl;
            seg_open_bytes = size;
        end
        else
        begin
            seg_open_bytes = sum[BYTES_W-1:0];
        end
        seg_prev_total = total;
        if (lvl >= NUM_LEVELS - 1)
        begin
            // last level flushes, then the run state starts over
            if (seg_open_bytes != '0)
                add_part(seg_open_start, lvl, seg_open_bytes);
            seg_prev_total = '0;
            seg_open_start = '0;
            seg_open_bytes = '0;
            seg_level      = '0;
            seg_parts      = 0;
        end
        else
        begin
            seg_level = lvl + 1'b1;
        end
        if (step_count > 0)
            step_parts[step_count-1].last_of_run = 1'b1;
        for (int i = 0; i < step_count; i++)
            pending_parts.push_back(step_parts[i]);
    endtask

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Offer one total; valid stays high afterwards until a later gap or a drain lowers it.
    task automatic send_total(input logic [BYTES_W-1:0] total);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        cumulative_bytes <= total;
        do
            @(posedge clk);
        while (in_stall);
        segment_level(total);
        last_total = total;
        beats_sent++;
    endtask

    task automatic send_size(input logic [BYTES_W-1:0] size);
        send_total(last_total + size);
    endtask

    // Input goes quiet until every owed part is out, then for the DRAIN_CYCLES margin.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_parts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [BYTES_W-1:0] value);
        wait_drained();
        cfg_valid  <= 1'b1;
        part_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        seg_limit = value;
        limit_writes++;
    endtask

    // Random next total: mostly sizes scaled to the limit, some at its edges,
    // some huge, and a few totals that go backwards.
    function automatic logic [BYTES_W-1:0] next_total(input logic [BYTES_W-1:0] lim);
        logic [BYTES_W-1:0] size;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 10)
            size = '0;
        else if (r < 45)
            size = (lim == '0) ? 64'($urandom_range(1, 8)) : rand64() % (lim / 2 + 1);
        else if (r < 65)
            size = (lim == '1) ? rand64() : rand64() % (lim + 1);
        else if (r < 80)
            size = lim + 64'($urandom_range(0, 2)) - 64'd1;
        else if (r < 92)
            size = rand64();
        else
            return (last_total == '0) ? '0 : rand64() % last_total;
        return last_total + size;
    endfunction

    // Receiver: check each accepted beat, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        part_beat_t got;
        part_beat_t want;
        int         r;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{part_index, first_cost, final_cost, part_bytes, oversized, last_of_run};
            if (pending_parts.size() == 0)
            begin
                note_failure($sformatf("unexpected part idx=%0d cost %0d..%0d bytes=%h",
                                       got.part_index, got.first_cost, got.final_cost,
                                       got.part_bytes));
            end
            else
            begin
                want = pending_parts.pop_front();
                if (got !== want)
                    note_failure($sformatf(
                        {"exp idx=%0d cost %0d..%0d bytes=%h over=%b last=%b / ",
                         "got idx=%0d cost %0d..%0d bytes=%h over=%b last=%b"},
                        want.part_index, want.first_cost, want.final_cost, want.part_bytes,
                        want.oversized, want.last_of_run, got.part_index, got.first_cost,
                        got.final_cost, got.part_bytes, got.oversized, got.last_of_run));
                parts_checked++;
            end
        end
        if (hold_request > 0)
        begin
            stall_left   = hold_request;
            stall_now    = 1'b1;
            hold_request = 0;
        end
        else if (stall_left == 0)
        begin
            r = $urandom_range(0, 99);
            stall_now = (r >= 60);
            if (r < 40)
                stall_left = $urandom_range(1, 4);
            else if (r < 60)
                stall_left = $urandom_range(20, 100);
            else if (r < 90)
                stall_left = $urandom_range(1, 3);
            else
                stall_left = $urandom_range(10, 40);
        end
        stall_left--;
        out_stall <= stall_now;
    end

    // Reset limit of all ones: zero-sized levels at the start, a total at the
    // top of the range, then a backward total whose sum carries out.
    task automatic test_default_limit();
        send_total(64'd0);
        send_total(64'd0);
        send_total(64'd5);
        send_total('1);
        send_total(64'd3);
        send_size(64'h8000_0000_0000_0000);
    endtask

    // Limit lowered mid-run under a large open part, then exact fit, overflow,
    // oversized behind an open part, and a zero limit.
    task automatic test_limit_updates();
        write_limit(64'd100);
        send_size(64'd0);
        send_size(64'd150);
        send_size(64'd60);
        send_size(64'd40);
        send_size(64'd1);
        send_size(64'd100);
        send_size(64'd101);
        write_limit(64'd0);
        send_size(64'd0);
        send_size(64'd1);
    endtask

    // Zero filler up to the last level, then a close and a flush on the last one.
    task automatic test_end_of_run();
        write_limit(64'd1000);
        while (seg_level != LVL_W'(NUM_LEVELS - 2))
            send_size(64'd0);
        send_size(64'd600);
        send_size(64'd600);
        send_size(64'd7);
    endtask

    // Receiver holds off while the sender keeps offering, so the queue fills
    // and in_stall rises; then the sender pauses mid-run until all is out.
    task automatic test_backpressure();
        gaps_on = 1'b0;
        write_limit(64'd50);
        hold_request = 300;
        repeat (40) send_size(64'($urandom_range(30, 60)));
        wait_drained();
        repeat (12) send_size(64'($urandom_range(0, 60)));
        gaps_on = 1'b1;
    endtask

    // Zero limit over a whole run: every nonzero level is its own part, so
    // the part cap drops the second half.
    task automatic test_part_cap();
        write_limit(64'd0);
        while (seg_level != '0)
            send_total(next_total(seg_limit));
        repeat (NUM_LEVELS) send_size(64'($urandom_range(1, 1000)));
    endtask

    task automatic test_random_phases();
        int phase;
        int kind;
        int target;
        logic [BYTES_W-1:0] lim;
        phase = 0;
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target)
        begin
            kind = (phase == 0) ? 2 : (phase == 1) ? 0 : $urandom_range(0, 6);
            case (kind)
                0: lim = '0;
                1: lim = 64'd1;
                2: lim = '1;
                3: lim = 64'h8000_0000_0000_0000;
                4: lim = rand64();
                5: lim = 64'($urandom_range(2, 64));
                default: lim = 64'($urandom_range(100, 5000));
            endcase
            write_limit(lim);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(30, 150)) send_total(next_total(seg_limit));
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        part_limit       = '0;
        in_valid         = 1'b0;
        cumulative_bytes = '0;
        out_stall        = 1'b0;
        seg_limit        = '1;
        seg_prev_total   = '0;
        seg_open_start   = '0;
        seg_open_bytes   = '0;
        seg_level        = '0;
        seg_parts        = 0;
        step_count       = 0;
        last_total       = '0;
        gaps_on          = 1'b1;
        hold_request     = 0;
        stall_left       = 0;
        stall_now        = 1'b0;
        errors           = 0;
        beats_sent       = 0;
        parts_checked    = 0;
        limit_writes     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_limit();
        test_limit_updates();
        test_end_of_run();
        test_backpressure();
        test_part_cap();
        test_random_phases();

        wait_drained();
        repeat (20) @(posedge clk);
        $display("summary: %0d level beats, %0d parts checked, %0d limit writes",
                 beats_sent, parts_checked, limit_writes);
        $display("summary: limits from zero to all ones, backward totals, part cap, %0d errors",
                 errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: size_limited_range_segmenter_core.f
rtl/sls_pkg.sv
rtl/sls_front.sv
rtl/sls_queue.sv
rtl/sls_back.sv
rtl/size_limited_range_segmenter_core.sv
test/size_limited_range_segmenter_core_test.sv
